FILE: design/cas_pkg.sv
// Shared types and constants for the command line argument splitter.
`timescale 1ns / 1ps

package cas_pkg;

   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // Longest backslash run held before the count saturates.
   localparam int unsigned MAX_BACKSLASH_RUN = 255;
   localparam int unsigned RUN_LIMIT =
      (MAX_BACKSLASH_RUN > 255) ? 255 : ((MAX_BACKSLASH_RUN < 1) ? 1 : MAX_BACKSLASH_RUN);
   localparam logic [7:0] RUN_CAP = 8'(RUN_LIMIT);

   typedef struct packed {
      logic       inside_arg;
      logic       inside_quotes;
      logic       quote_pending;
      logic [7:0] pending_backslashes;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] backslash_run;
      logic [7:0] out_char;
      logic       has_char;
      logic       arg_end;
      logic       line_done;
   } result_type;

endpackage

FILE: design/command_line_argument_splitter_top.sv
// Top level of the command line argument splitter.
`timescale 1ns / 1ps
// Output: a character's result is registered and appears on rsp_ in the cycle after its transaction.
// Throughput: one character per cycle; req_ready drops only while a held
//   result is stalled by rsp_ready low.
// Reset: synchronous, active high; clears the parser state and the result
//   register's valid flag.

module command_line_argument_splitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_backslash_run,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_arg_end,
   output logic       rsp_line_done
);
   import cas_pkg::*;

   // Parser state: argument open, quoting, pending quote, backslash count.
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      step_result;
   result_type      held_result;
   logic            step_emit;
   logic            accept;
   logic            can_load;

   // Accept a new character whenever the result register can take its result.
   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;

   cas_step u_step (
      .state      (state_ff),
      .ch         (req_ch),
      .line_end   (req_line_end),
      .next_state (state_in),
      .result     (step_result),
      .emit       (step_emit)
   );

   // Advance parser state only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Characters that give no result (backslashes, some separators and quotes) leave
   // the register empty once any held result has drained.
   cas_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_valid (step_emit),
      .load_data  (step_result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .can_load   (can_load),
      .rsp_data   (held_result)
   );

   assign rsp_backslash_run = held_result.backslash_run;
   assign rsp_out_char      = held_result.out_char;
   assign rsp_has_char      = held_result.has_char;
   assign rsp_arg_end       = held_result.arg_end;
   assign rsp_line_done     = held_result.line_done;

endmodule

FILE: design/cas_step.sv
// Per-character parse step: next parser state and the optional result.
`timescale 1ns / 1ps

module cas_step (
   input  cas_pkg::parse_state_type state,
   input  logic [7:0]               ch,
   input  logic                     line_end,
   output cas_pkg::parse_state_type next_state,
   output cas_pkg::result_type      result,
   output logic                     emit
);
   import cas_pkg::*;

   always_comb begin
      parse_state_type ns;
      result_type      r;
      logic            e;
      logic            resolved;
      ns       = state;
      r        = '0;
      e        = 1'b0;
      resolved = 1'b0;
      if (line_end) begin
         r.backslash_run = state.pending_backslashes;
         r.arg_end       = state.inside_arg;
         r.line_done     = 1'b1;
         e               = 1'b1;
         ns              = '0;
      end else begin
         if (state.quote_pending) begin
            ns.quote_pending = 1'b0;
            if (ch == CHAR_QUOTE) begin
               r.out_char = CHAR_QUOTE;
               r.has_char = 1'b1;
               e          = 1'b1;
               resolved   = 1'b1;
            end else begin
               ns.inside_quotes = 1'b0;
            end
         end
         if (!resolved) begin
            priority if (ch == CHAR_BACKSLASH) begin
               ns.inside_arg = 1'b1;
               if (state.pending_backslashes < RUN_CAP) begin
                  ns.pending_backslashes = state.pending_backslashes + 8'd1;
               end
            end else if (ch == CHAR_QUOTE) begin
               ns.inside_arg          = 1'b1;
               ns.pending_backslashes = '0;
               if (state.pending_backslashes != 8'd0) begin
                  e               = 1'b1;
                  r.backslash_run = state.pending_backslashes >> 1;
                  if (state.pending_backslashes[0]) begin
                     r.out_char = CHAR_QUOTE;
                     r.has_char = 1'b1;
                  end else begin
                     ns.inside_quotes = ~ns.inside_quotes;
                  end
               end else if (ns.inside_quotes) begin
                  ns.quote_pending = 1'b1;
               end else begin
                  ns.inside_quotes = 1'b1;
               end
            end else if ((ch == CHAR_SPACE || ch == CHAR_TAB) && !ns.inside_quotes) begin
               if (state.inside_arg) begin
                  e               = 1'b1;
                  r.backslash_run = state.pending_backslashes;
                  r.arg_end       = 1'b1;
               end
               ns.inside_arg          = 1'b0;
               ns.pending_backslashes = '0;
            end else begin
               e                      = 1'b1;
               r.backslash_run        = state.pending_backslashes;
               r.out_char             = ch;
               r.has_char             = 1'b1;
               ns.pending_backslashes = '0;
               ns.inside_arg          = 1'b1;
            end
         end
      end
      next_state = ns;
      result     = r;
      emit       = e;
   end

endmodule

FILE: design/cas_rsp_reg.sv
// Result register: holds one result transaction until the consumer takes it.
`timescale 1ns / 1ps

module cas_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                load_valid,
   input  cas_pkg::result_type load_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                can_load,
   output cas_pkg::result_type rsp_data
);
   import cas_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Free when empty or when the held result leaves this cycle.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
